// File: sv/icdf_pkg.sv
// package with types, codes and constants of the inverse cdf table interpolator
`timescale 1ns / 1ps
`default_nettype none

package icdf_pkg;

  localparam int unsigned X_W     = 32;
  localparam int unsigned P_W     = 17;
  localparam int unsigned IDX_W   = 11;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned DEPTH_DEFAULT = 2048;

  localparam logic [CNT_W-1:0] ENTRIES_RST = 12'd2048;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic [1:0] CLAMP_NONE  = 2'd0;
  localparam logic [1:0] CLAMP_FIRST = 2'd1;
  localparam logic [1:0] CLAMP_LAST  = 2'd2;

  // divider: two quotient bits per cycle over a 50-bit dividend
  localparam int unsigned DIVD_W    = 50;
  localparam int unsigned DIV_STEPS = DIVD_W / 2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PROBE,
    S_CMP,
    S_SEL,
    S_EDGE,
    S_RD1,
    S_RD2,
    S_MUL,
    S_PREP,
    S_DIV,
    S_FIX,
    S_OUT
  } state_e;

  typedef struct packed {
    logic                    action;
    logic [IDX_W-1:0]        entry_index;
    logic signed [X_W-1:0]   entry_x;
    logic [P_W-1:0]          entry_prob;
    logic [P_W-1:0]          query_prob;
  } in_item_t;

  typedef struct packed {
    logic signed [X_W-1:0] sample_x;
    logic [1:0]            clamp_code;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/icdf_in_if.sv
// handshake channel carrying load and query items
`timescale 1ns / 1ps
`default_nettype none

interface icdf_in_if;
  logic               valid;
  logic               ready;
  icdf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/icdf_out_if.sv
// handshake channel carrying lookup results
`timescale 1ns / 1ps
`default_nettype none

interface icdf_out_if;
  logic                valid;
  logic                ready;
  icdf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: sv/inverse_cdf_table_interpolator_top.sv
// top level of the piecewise linear inverse cdf table lookup
`timescale 1ns / 1ps
`default_nettype none

// Holds a table of points x[k] (signed Q16.16) and ascending probabilities p[k] (Q1.16)
// in one single-port-read memory. A load item writes one entry.
// A query item binary-searches the first n entries (n = entries_in_use, clipped to
// 1..TABLE_DEPTH) for the first p[k] >= u, then either returns a clamped end point or
// interpolates between entries k-1 and k; the quotient truncates toward zero.
// Each of the s search steps, s at most floor(log2(n)) + 1, reads the memory into a
// register in S_PROBE and compares in S_CMP. When p[k-1] equals p[k] the result is
// x[k-1] with no division; otherwise the restoring divider retires two quotient bits
// a cycle. A query also waits while the previous result still sits unaccepted in the
// output register. Input ready is high only while no query is in flight and returns
// in the same cycle as the result becomes valid; new items are taken while a result
// waits. entries_in_use may be written only while the block is idle.
module inverse_cdf_table_interpolator_top #(
  parameter int unsigned TABLE_DEPTH = icdf_pkg::DEPTH_DEFAULT
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [icdf_pkg::CNT_W-1:0] cfg_wdata_i,
  icdf_in_if.sink                         req_i,
  icdf_out_if.source                      rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned WW = (CW > icdf_pkg::CNT_W) ? CW : icdf_pkg::CNT_W;
  localparam int unsigned DCW = $clog2(icdf_pkg::DIV_STEPS);
  localparam int unsigned DW = icdf_pkg::DIVD_W;
  localparam int unsigned XW = icdf_pkg::X_W;
  localparam int unsigned PW = icdf_pkg::P_W;

  localparam logic [WW-1:0]  DEPTH_W  = WW'(TABLE_DEPTH);
  localparam logic [DCW-1:0] DIV_LAST = DCW'(icdf_pkg::DIV_STEPS - 1);

  icdf_pkg::state_e state_q, state_d;

  logic [icdf_pkg::CNT_W-1:0] entries_q;
  logic                       out_valid_q;
  icdf_pkg::out_item_t        out_data_q;

  // table memory
  logic [XW-1:0] mem_x [TABLE_DEPTH];
  logic [PW-1:0] mem_p [TABLE_DEPTH];
  logic [XW-1:0] rd_x_q;
  logic [PW-1:0] rd_p_q;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          mem_we;

  logic          in_xfer;
  logic          out_free;
  logic [WW-1:0] idx_w;
  logic [WW-1:0] cfg_w;
  logic [WW-1:0] n_sel;

  // search and datapath
  logic [CW-1:0]        n_q;
  logic [CW-1:0]        first_q;
  logic [CW-1:0]        count_q;
  logic [CW-1:0]        half;
  logic [CW-1:0]        probe;
  logic [CW-1:0]        count_next;
  logic                 probe_lt;
  logic [PW-1:0]        u_q;
  logic [1:0]           code_q;
  logic signed [XW-1:0] x0_q;
  logic [PW-1:0]        y0_q;
  logic signed [XW:0]   dx_q;
  logic signed [PW:0]   du_q;
  logic signed [PW:0]   den_q;
  logic signed [DW:0]   prod_q;
  logic signed [DW:0]   prod_neg;
  logic signed [PW:0]   den_neg;
  logic [DW-1:0]        quo_q;
  logic [PW-1:0]        rem_q;
  logic [PW-1:0]        dvs_q;
  logic                 neg_q;
  logic [DCW-1:0]       div_cnt_q;
  logic [DW-1:0]        quo_d;
  logic [PW-1:0]        rem_d;
  logic [PW:0]          trial;
  logic signed [DW:0]   q_signed;
  logic signed [DW+1:0] sum;
  logic signed [XW-1:0] sum_sat;
  logic signed [XW-1:0] res_q;

  assign in_xfer  = req_i.valid && req_i.ready;
  assign out_free = !out_valid_q || rsp_o.ready;

  assign idx_w  = WW'(req_i.data.entry_index);
  assign waddr  = idx_w[AW-1:0];
  assign mem_we = in_xfer && (req_i.data.action == icdf_pkg::ACT_LOAD) && (idx_w < DEPTH_W);

  assign cfg_w = WW'(entries_q);
  always_comb begin
    if (cfg_w == '0) begin
      n_sel = WW'(1);
    end else if (cfg_w > DEPTH_W) begin
      n_sel = DEPTH_W;
    end else begin
      n_sel = cfg_w;
    end
  end

  assign half       = count_q >> 1;
  assign probe      = first_q + half;
  assign probe_lt   = rd_p_q < u_q;
  assign count_next = probe_lt ? (count_q - half - CW'(1)) : half;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      icdf_pkg::S_IDLE: begin
        if (in_xfer && (req_i.data.action == icdf_pkg::ACT_QUERY)) begin
          state_d = icdf_pkg::S_PROBE;
        end
      end
      icdf_pkg::S_PROBE: state_d = icdf_pkg::S_CMP;
      icdf_pkg::S_CMP: begin
        state_d = (count_next == '0) ? icdf_pkg::S_SEL : icdf_pkg::S_PROBE;
      end
      icdf_pkg::S_SEL: begin
        if ((first_q == '0) || (first_q >= n_q)) begin
          state_d = icdf_pkg::S_EDGE;
        end else begin
          state_d = icdf_pkg::S_RD1;
        end
      end
      icdf_pkg::S_EDGE: state_d = icdf_pkg::S_OUT;
      icdf_pkg::S_RD1:  state_d = icdf_pkg::S_RD2;
      icdf_pkg::S_RD2:  state_d = icdf_pkg::S_MUL;
      icdf_pkg::S_MUL: begin
        state_d = (den_q == '0) ? icdf_pkg::S_OUT : icdf_pkg::S_PREP;
      end
      icdf_pkg::S_PREP: state_d = icdf_pkg::S_DIV;
      icdf_pkg::S_DIV: begin
        if (div_cnt_q == DIV_LAST) begin
          state_d = icdf_pkg::S_FIX;
        end
      end
      icdf_pkg::S_FIX: state_d = icdf_pkg::S_OUT;
      icdf_pkg::S_OUT: begin
        if (out_free) begin
          state_d = icdf_pkg::S_IDLE;
        end
      end
      default: state_d = icdf_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    raddr       = '0;
    req_i.ready = 1'b0;
    case (state_q)
      icdf_pkg::S_IDLE:  req_i.ready = 1'b1;
      icdf_pkg::S_PROBE: raddr = probe[AW-1:0];
      icdf_pkg::S_SEL: begin
        if (first_q == '0) begin
          raddr = '0;
        end else if (first_q >= n_q) begin
          raddr = AW'(n_q - CW'(1));
        end else begin
          raddr = AW'(first_q - CW'(1));
        end
      end
      icdf_pkg::S_RD1: raddr = first_q[AW-1:0];
      default: raddr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_x[waddr] <= req_i.data.entry_x;
      mem_p[waddr] <= req_i.data.entry_prob;
    end
    rd_x_q <= mem_x[raddr];
    rd_p_q <= mem_p[raddr];
  end

  // divider, two restoring steps per cycle
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    trial = '0;
    for (int i = 0; i < 2; i++) begin
      trial = {rem_d, quo_d[DW-1]};
      quo_d = {quo_d[DW-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        trial    = trial - {1'b0, dvs_q};
        quo_d[0] = 1'b1;
      end
      rem_d = trial[PW-1:0];
    end
  end

  assign prod_neg = -prod_q;
  assign den_neg  = -den_q;
  assign q_signed = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign sum      = $signed({{(DW + 2 - XW){x0_q[XW-1]}}, x0_q})
                  + $signed({q_signed[DW], q_signed});

  always_comb begin
    if (sum[DW+1:XW-1] == '0 || sum[DW+1:XW-1] == '1) begin
      sum_sat = sum[XW-1:0];
    end else if (sum[DW+1]) begin
      sum_sat = {1'b1, {(XW - 1){1'b0}}};
    end else begin
      sum_sat = {1'b0, {(XW - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      icdf_pkg::S_IDLE: begin
        n_q     <= CW'(n_sel);
        first_q <= '0;
        count_q <= CW'(n_sel);
        u_q     <= req_i.data.query_prob;
      end
      icdf_pkg::S_CMP: begin
        if (probe_lt) begin
          first_q <= probe + CW'(1);
        end
        count_q <= count_next;
      end
      icdf_pkg::S_SEL: begin
        if (first_q == '0) begin
          code_q <= icdf_pkg::CLAMP_FIRST;
        end else if (first_q >= n_q) begin
          code_q <= icdf_pkg::CLAMP_LAST;
        end else begin
          code_q <= icdf_pkg::CLAMP_NONE;
        end
      end
      icdf_pkg::S_EDGE: res_q <= rd_x_q;
      icdf_pkg::S_RD1: begin
        x0_q <= rd_x_q;
        y0_q <= rd_p_q;
      end
      icdf_pkg::S_RD2: begin
        dx_q  <= $signed({rd_x_q[XW-1], rd_x_q}) - $signed({x0_q[XW-1], x0_q});
        du_q  <= $signed({1'b0, u_q}) - $signed({1'b0, y0_q});
        den_q <= $signed({1'b0, rd_p_q}) - $signed({1'b0, y0_q});
      end
      icdf_pkg::S_MUL: begin
        prod_q <= du_q * dx_q;
        res_q  <= x0_q;
      end
      icdf_pkg::S_PREP: begin
        quo_q     <= prod_q[DW] ? prod_neg[DW-1:0] : prod_q[DW-1:0];
        dvs_q     <= den_q[PW] ? den_neg[PW-1:0] : den_q[PW-1:0];
        rem_q     <= '0;
        neg_q     <= prod_q[DW] ^ den_q[PW];
        div_cnt_q <= '0;
      end
      icdf_pkg::S_DIV: begin
        quo_q     <= quo_d;
        rem_q     <= rem_d;
        div_cnt_q <= div_cnt_q + DCW'(1);
      end
      icdf_pkg::S_FIX: res_q <= sum_sat;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= icdf_pkg::S_IDLE;
      entries_q   <= icdf_pkg::ENTRIES_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        entries_q <= cfg_wdata_i;
      end
      if ((state_q == icdf_pkg::S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == icdf_pkg::S_OUT) && out_free) begin
      out_data_q.sample_x   <= res_q;
      out_data_q.clamp_code <= code_q;
    end
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

endmodule

`default_nettype wire

// File: tb/inverse_cdf_table_interpolator_top_test.sv
// testbench of the inverse cdf table interpolator: table loads, lookups and scoreboard
`timescale 1ns / 1ps

module inverse_cdf_table_interpolator_top_test;
  import icdf_pkg::*;

  localparam int unsigned DEPTH         = DEPTH_DEFAULT;
  localparam int unsigned RANDOM_ITEMS  = 1350;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned PROB_MAX      = 131071;

  class inverse_cdf_predictor;
    logic signed [X_W-1:0] point_mem [DEPTH];
    logic [P_W-1:0]        prob_mem [DEPTH];
    logic [CNT_W-1:0]      entry_count;
    out_item_t             expected_samples [$];
    int unsigned           errors;

    function new();
      entry_count = ENTRIES_RST;
      errors = 0;
      foreach (point_mem[k]) begin
        point_mem[k] = '0;
        prob_mem[k] = '0;
      end
    endfunction

    function void set_entry_count(logic [CNT_W-1:0] value);
      entry_count = value;
    endfunction

    function int unsigned active_entries();
      int unsigned n;
      n = 32'(entry_count);
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      return n;
    endfunction

    function out_item_t invert_cdf(logic [P_W-1:0] u);
      int unsigned n, first, span, half, probe;
      longint x0, x1, y0, y1, den, res;
      out_item_t r;
      n = active_entries();
      first = 0;
      span = n;
      while (span > 0) begin
        half = span / 2;
        probe = first + half;
        if (prob_mem[probe] < u) begin
          first = probe + 1;
          span -= half + 1;
        end else begin
          span = half;
        end
      end
      if (first == 0) begin
        r.sample_x = point_mem[0];
        r.clamp_code = CLAMP_FIRST;
      end else if (first >= n) begin
        r.sample_x = point_mem[n-1];
        r.clamp_code = CLAMP_LAST;
      end else begin
        x0 = longint'(point_mem[first-1]);
        x1 = longint'(point_mem[first]);
        y0 = longint'(prob_mem[first-1]);
        y1 = longint'(prob_mem[first]);
        den = y1 - y0;
        if (den == 0) begin
          res = x0;
        end else begin
          res = x0 + (longint'(u) - y0) * (x1 - x0) / den;
          if (res > 64'sd2147483647) res = 64'sd2147483647;
          if (res < -64'sd2147483648) res = -64'sd2147483648;
        end
        r.sample_x = res[X_W-1:0];
        r.clamp_code = CLAMP_NONE;
      end
      return r;
    endfunction

    function void note_item(in_item_t it);
      if (it.action == ACT_LOAD) begin
        if (it.entry_index < DEPTH) begin
          point_mem[it.entry_index] = it.entry_x;
          prob_mem[it.entry_index] = it.entry_prob;
        end
      end else begin
        expected_samples.push_back(invert_cdf(it.query_prob));
      end
    endfunction

    function void check_sample(out_item_t got);
      out_item_t want;
      if (expected_samples.size() == 0) begin
        $error("unexpected result: sample_x %0d clamp_code %0d", got.sample_x, got.clamp_code);
        errors++;
        return;
      end
      want = expected_samples.pop_front();
      if (got.sample_x !== want.sample_x) begin
        $error("sample_x: expected %0d, actual %0d", want.sample_x, got.sample_x);
        errors++;
      end
      if (got.clamp_code !== want.clamp_code) begin
        $error("clamp_code: expected %0d, actual %0d", want.clamp_code, got.clamp_code);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  bit               steady;
  int unsigned      cycle_count = 0;
  int unsigned      random_items;

  icdf_in_if  req_if ();
  icdf_out_if rsp_if ();

  inverse_cdf_predictor predictor = new();

  inverse_cdf_table_interpolator_top #(
    .TABLE_DEPTH(DEPTH)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_if),
    .rsp_o      (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** inverse_cdf_table_interpolator_top: FAILED **");
      $finish;
    end
  end

  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.data <= it;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predictor.note_item(it);
    random_items++;
  endtask

  function automatic in_item_t noise_item();
    logic [95:0] bits;
    in_item_t it;
    bits = {$urandom(), $urandom(), $urandom()};
    it = bits[$bits(in_item_t)-1:0];
    return it;
  endfunction

  task automatic load_entry(int unsigned idx, logic [X_W-1:0] x, logic [P_W-1:0] p);
    in_item_t it;
    it = noise_item();
    it.action = ACT_LOAD;
    it.entry_index = idx[IDX_W-1:0];
    it.entry_x = x;
    it.entry_prob = p;
    send_item(it);
  endtask

  task automatic lookup(logic [P_W-1:0] u);
    in_item_t it;
    it = noise_item();
    it.action = ACT_QUERY;
    it.query_prob = u;
    send_item(it);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (predictor.expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_entry_count(logic [CNT_W-1:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    predictor.set_entry_count(value);
  endtask

  task automatic accept_results();
    int unsigned gap;
    forever begin
      gap = steady ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        @(posedge clk_i);
        while (!rsp_if.valid) @(posedge clk_i);
        repeat (gap - 1) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!rsp_if.valid) @(posedge clk_i);
      predictor.check_sample(rsp_if.data);
    end
  endtask

  // ascending or scrambled contents for the first m entries
  task automatic build_table(int unsigned m, bit ascending);
    int unsigned p, step_max;
    p = $urandom_range(0, 40000);
    step_max = (PROB_MAX - p) / m;
    for (int unsigned k = 0; k < m; k++) begin
      if (ascending) begin
        load_entry(k, $urandom(), p[P_W-1:0]);
        p += $urandom_range(0, step_max);
      end else begin
        load_entry(k, $urandom(), P_W'($urandom_range(0, PROB_MAX)));
      end
    end
  endtask

  function automatic logic [P_W-1:0] pick_prob(int unsigned nact);
    int unsigned idx, base;
    idx = $urandom_range(0, nact - 1);
    base = 32'(predictor.prob_mem[idx]);
    case ($urandom_range(0, 5))
      0: return P_W'($urandom_range(0, PROB_MAX));
      1: return P_W'(base);
      2: return (base == 0) ? '0 : P_W'(base - 1);
      3: return (base == PROB_MAX) ? P_W'(PROB_MAX) : P_W'(base + 1);
      4: return ($urandom_range(0, 1) == 1) ? 17'd65536 : 17'd0;
      default: begin
        return ($urandom_range(0, 1) == 1) ? P_W'(PROB_MAX) : P_W'($urandom_range(0, 65536));
      end
    endcase
  endfunction

  initial begin
    int unsigned n, nact, m, burst;
    logic [X_W-1:0] x;
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_wdata_i <= '0;
    req_if.valid <= 1'b0;
    req_if.data <= '0;
    rsp_if.ready <= 1'b0;
    steady = 1'b0;
    random_items = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      accept_results();
    join_none

    // whole table, ascending, so no lookup ever reads an unwritten entry
    for (int unsigned k = 0; k < DEPTH; k++) begin
      x = 32'h8000_0000 + k * 32'h20_0000 + $urandom_range(0, 32'h1f_ffff);
      if (k == 0) x = 32'h8000_0000;
      if (k == DEPTH - 1) x = 32'h7fff_ffff;
      load_entry(k, x, P_W'(k * 32 + $urandom_range(0, 31)));
    end

    lookup(P_W'(0));
    lookup(P_W'(1));
    lookup(P_W'(32));
    lookup(P_W'(65535));
    lookup(P_W'(65536));
    lookup(P_W'(65537));
    lookup(P_W'(PROB_MAX));
    lookup(predictor.prob_mem[1000]);
    lookup(predictor.prob_mem[1000] + P_W'(1));
    lookup(predictor.prob_mem[DEPTH-1]);

    write_entry_count(CNT_W'(0));
    lookup(P_W'(0));
    lookup(P_W'(PROB_MAX));
    lookup(predictor.prob_mem[0]);

    write_entry_count(12'd4095);
    lookup(P_W'(PROB_MAX));
    lookup(predictor.prob_mem[DEPTH-1]);
    lookup(P_W'(1));

    write_entry_count(CNT_W'(2));
    lookup(P_W'(0));
    lookup(predictor.prob_mem[1]);
    lookup(predictor.prob_mem[0] + P_W'(1));
    lookup(P_W'(PROB_MAX));

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: n = $urandom_range(0, 1);
        1: n = ($urandom_range(0, 1) == 1) ? DEPTH : $urandom_range(DEPTH, 4095);
        2: n = $urandom_range(49, DEPTH - 1);
        default: n = $urandom_range(2, 48);
      endcase
      write_entry_count(n[CNT_W-1:0]);
      nact = predictor.active_entries();
      steady = ($urandom_range(0, 3) == 0);
      m = (nact > 48) ? 48 : nact;
      build_table(m, $urandom_range(0, 4) != 0);
      burst = $urandom_range(10, 30);
      repeat (burst) begin
        if ($urandom_range(0, 6) == 0) begin
          load_entry($urandom_range(0, 3) == 0 ? $urandom_range(0, DEPTH - 1)
                                               : $urandom_range(0, m - 1),
                     $urandom(), P_W'($urandom_range(0, PROB_MAX)));
        end else begin
          lookup(pick_prob(nact));
        end
      end
    end

    steady = 1'b0;
    wait_drained();
    if (predictor.errors == 0 && predictor.expected_samples.size() == 0) begin
      $display("** inverse_cdf_table_interpolator_top: PASSED **");
    end else begin
      $display("** inverse_cdf_table_interpolator_top: FAILED **");
    end
    $finish;
  end

endmodule
